// ===== sv/tlkc_pkg.sv =====
// Shared types and constants of the text line keyword classifier.
package tlkc_pkg;

    // Chunk length counter width; covers the largest allowed chunk size.
    localparam int LEN_W = 7;

    localparam int MAX_CHUNK_DEFAULT   = 99;
    localparam int COUNT_WIDTH_DEFAULT = 16;

    // Width of the count fields on the result port.
    localparam int OUT_COUNT_W = 16;

    // Bytes of the match window: up to five previous bytes plus the new one.
    localparam int WIN_BYTES = 6;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [23:0] KW_INT    = "int";
    localparam logic [39:0] KW_FLOAT  = "float";
    localparam logic [47:0] KW_RETURN = "return";
    localparam logic [15:0] KW_IF     = "if";
    localparam logic [31:0] KW_ELSE   = "else";
    localparam logic [23:0] KW_FOR    = "for";
    localparam logic [39:0] KW_WHILE  = "while";
    localparam logic [47:0] KW_PRINTF = "printf";
    localparam logic [15:0] CMT_MARK  = "//";

    // Flags of one finished chunk, handed from front to back.
    typedef struct packed {
        logic blank;
        logic keyword;
        logic comment;
        logic last;
    } chunk_rec_t;

endpackage

// ===== sv/tlkc_front.sv =====
// Front end: takes bytes, matches keywords and builds chunk records.
module tlkc_front #(
    parameter int MAX_CHUNK = tlkc_pkg::MAX_CHUNK_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           ch,
    input  logic                 end_of_text,
    input  logic                 q_full,
    output logic                 push,
    output tlkc_pkg::chunk_rec_t push_rec
);

    localparam int HIST_W = 8 * (tlkc_pkg::WIN_BYTES - 1);

    logic [HIST_W-1:0]          recent_reg, recent_next;
    logic [tlkc_pkg::LEN_W-1:0] len_reg, len_next, len_inc;
    logic                       nonblank_reg, nonblank_next;
    logic                       kw_reg, kw_next;
    logic                       cmt_reg, cmt_next;

    logic [8*tlkc_pkg::WIN_BYTES-1:0] window;
    logic accept, chunk_end, is_blank, kw_hit, cmt_hit;
    logic nb_now, kw_now, cmt_now;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign window   = {recent_reg, ch};
    assign len_inc  = len_reg + tlkc_pkg::LEN_W'(1);

    // History is zero at chunk start and no keyword letter is zero,
    // so a match can never reach back across a chunk boundary.
    assign kw_hit = (window[23:0] == tlkc_pkg::KW_INT)    ||
                    (window[39:0] == tlkc_pkg::KW_FLOAT)  ||
                    (window[47:0] == tlkc_pkg::KW_RETURN) ||
                    (window[15:0] == tlkc_pkg::KW_IF)     ||
                    (window[31:0] == tlkc_pkg::KW_ELSE)   ||
                    (window[23:0] == tlkc_pkg::KW_FOR)    ||
                    (window[39:0] == tlkc_pkg::KW_WHILE)  ||
                    (window[47:0] == tlkc_pkg::KW_PRINTF);
    assign cmt_hit = (window[15:0] == tlkc_pkg::CMT_MARK);

    assign is_blank = (ch == tlkc_pkg::CH_SPACE) || (ch == tlkc_pkg::CH_TAB) ||
                      (ch == tlkc_pkg::CH_CR)    || (ch == tlkc_pkg::CH_LF);

    assign nb_now  = nonblank_reg || !is_blank;
    assign kw_now  = kw_reg || kw_hit;
    assign cmt_now = cmt_reg || cmt_hit;

    assign chunk_end = (ch == tlkc_pkg::CH_LF) ||
                       (len_inc == tlkc_pkg::LEN_W'(MAX_CHUNK)) || end_of_text;

    assign push             = accept && chunk_end;
    assign push_rec.blank   = !nb_now;
    assign push_rec.keyword = kw_now;
    assign push_rec.comment = cmt_now;
    assign push_rec.last    = end_of_text;

    always_comb
    begin
        recent_next   = recent_reg;
        len_next      = len_reg;
        nonblank_next = nonblank_reg;
        kw_next       = kw_reg;
        cmt_next      = cmt_reg;
        if (accept)
        begin
            if (chunk_end)
            begin
                recent_next   = '0;
                len_next      = '0;
                nonblank_next = 1'b0;
                kw_next       = 1'b0;
                cmt_next      = 1'b0;
            end
            else
            begin
                recent_next   = window[HIST_W-1:0];
                len_next      = len_inc;
                nonblank_next = nb_now;
                kw_next       = kw_now;
                cmt_next      = cmt_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg   <= '0;
            len_reg      <= '0;
            nonblank_reg <= 1'b0;
            kw_reg       <= 1'b0;
            cmt_reg      <= 1'b0;
        end
        else
        begin
            recent_reg   <= recent_next;
            len_reg      <= len_next;
            nonblank_reg <= nonblank_next;
            kw_reg       <= kw_next;
            cmt_reg      <= cmt_next;
        end
    end

endmodule

// ===== sv/tlkc_queue.sv =====
// Two-entry queue of chunk records between front and back.
module tlkc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tlkc_pkg::chunk_rec_t push_rec,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output tlkc_pkg::chunk_rec_t pop_rec
);

    tlkc_pkg::chunk_rec_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_rec   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== sv/tlkc_back.sv =====
// Back end: chunk counters and the result output register.
module tlkc_back #(
    parameter int COUNT_WIDTH = tlkc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_not_empty,
    input  tlkc_pkg::chunk_rec_t q_rec,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 blank,
    output logic                 has_keyword,
    output logic                 has_comment,
    output logic [tlkc_pkg::OUT_COUNT_W-1:0] blank_count,
    output logic [tlkc_pkg::OUT_COUNT_W-1:0] keyword_count,
    output logic                 final_res
);

    localparam int EXT_W = (COUNT_WIDTH > tlkc_pkg::OUT_COUNT_W) ?
                           COUNT_WIDTH : tlkc_pkg::OUT_COUNT_W;

    logic [COUNT_WIDTH-1:0] blank_tot_reg, blank_tot_next;
    logic [COUNT_WIDTH-1:0] kw_tot_reg, kw_tot_next;
    logic                   valid_reg, valid_next;
    tlkc_pkg::chunk_rec_t   rec_reg;
    logic [EXT_W-1:0]       blank_ext, kw_ext;

    assign pop = q_not_empty && (!valid_reg || out_ready);

    always_comb
    begin
        blank_tot_next = blank_tot_reg;
        kw_tot_next    = kw_tot_reg;
        valid_next     = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            if (q_rec.blank && (blank_tot_reg != '1))
                blank_tot_next = blank_tot_reg + COUNT_WIDTH'(1);
            if (q_rec.keyword && (kw_tot_reg != '1))
                kw_tot_next = kw_tot_reg + COUNT_WIDTH'(1);
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            rec_reg <= q_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            blank_tot_reg <= '0;
            kw_tot_reg    <= '0;
        end
        else
        begin
            valid_reg     <= valid_next;
            blank_tot_reg <= blank_tot_next;
            kw_tot_reg    <= kw_tot_next;
        end
    end

    assign blank_ext = EXT_W'(blank_tot_reg);
    assign kw_ext    = EXT_W'(kw_tot_reg);

    assign out_valid     = valid_reg;
    assign blank         = rec_reg.blank;
    assign has_keyword   = rec_reg.keyword;
    assign has_comment   = rec_reg.comment;
    assign final_res     = rec_reg.last;
    assign blank_count   = blank_ext[tlkc_pkg::OUT_COUNT_W-1:0];
    assign keyword_count = kw_ext[tlkc_pkg::OUT_COUNT_W-1:0];

endmodule

// ===== sv/text_line_keyword_classifier.sv =====
// Text line classifier: splits a byte stream into chunks and flags each one.
//
// Input channel (in_valid/in_ready): one text byte ch per request, with
// end_of_text marking the last byte of the text. A chunk closes at a
// newline, at MAX_CHUNK bytes, or at the end-marked byte.
// Output channel (out_valid/out_ready): one request per closed chunk with
// blank, has_keyword, has_comment, final_res and the saturating totals
// blank_count and keyword_count (low 16 bits of COUNT_WIDTH-bit counters).
// Throughput: one byte per cycle while the queue is not full; the keyword
// window and chunk flags are updated by the front end as each byte is taken.
// Path: the record of the byte closing a chunk is written into the queue,
// then loads the output register once that register is empty or is being
// read with out_ready high.
// Stall: when out_ready is low, up to two finished chunks wait in the
// queue; in_ready drops only once the queue is full.
// Reset: rst_n clears the current chunk, the counters, the queue and the output valid flag.
module text_line_keyword_classifier #(
    parameter int MAX_CHUNK   = tlkc_pkg::MAX_CHUNK_DEFAULT,
    parameter int COUNT_WIDTH = tlkc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        blank,
    output logic        has_keyword,
    output logic        has_comment,
    output logic [15:0] blank_count,
    output logic [15:0] keyword_count,
    output logic        final_res
);

    logic                 q_full, q_not_empty, push, pop;
    tlkc_pkg::chunk_rec_t push_rec, pop_rec;

    tlkc_front #(
        .MAX_CHUNK(MAX_CHUNK)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .push        (push),
        .push_rec    (push_rec)
    );

    tlkc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_rec   (pop_rec)
    );

    tlkc_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_rec         (pop_rec),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .blank         (blank),
        .has_keyword   (has_keyword),
        .has_comment   (has_comment),
        .blank_count   (blank_count),
        .keyword_count (keyword_count),
        .final_res     (final_res)
    );

endmodule

// ===== sv/tlkc_checker.sv =====
// Port-level checks for the text line classifier, bound to the top level.
module tlkc_checker #(
    parameter int COUNT_WIDTH = tlkc_pkg::COUNT_WIDTH_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        blank,
    input logic        has_keyword,
    input logic        has_comment,
    input logic [15:0] blank_count,
    input logic [15:0] keyword_count,
    input logic        final_res
);

    localparam bit WRAPS = (COUNT_WIDTH > 16);

    // Reset seen at an edge leaves no result showing at the next one.
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high after reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(blank_count)
            && $stable(keyword_count) && $stable(final_res) && $stable(blank))
        else $error("stalled result changed");

    // A whitespace-only chunk cannot contain a keyword or a comment mark.
    a_blank_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && blank |-> !has_keyword && !has_comment)
        else $error("blank chunk flagged with keyword or comment");

    a_blank_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && blank |-> WRAPS || (blank_count != 16'd0))
        else $error("blank chunk not counted");

    a_kw_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_keyword |-> WRAPS || (keyword_count != 16'd0))
        else $error("keyword chunk not counted");

endmodule

bind text_line_keyword_classifier tlkc_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
) u_tlkc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .blank         (blank),
    .has_keyword   (has_keyword),
    .has_comment   (has_comment),
    .blank_count   (blank_count),
    .keyword_count (keyword_count),
    .final_res     (final_res)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the text line keyword classifier.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1100;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 12;
    localparam int DRAIN_WAIT  = 10;

    typedef struct packed {
        logic        blank;
        logic        keyword;
        logic        comment;
        logic [15:0] blank_count;
        logic [15:0] keyword_count;
        logic        last;
    } chunk_result_t;

    class chunk_scoreboard;
        logic [39:0]                              history;
        logic [tlkc_pkg::LEN_W-1:0]               chunk_len;
        bit                                       saw_nonblank;
        bit                                       saw_keyword;
        bit                                       saw_comment;
        logic [tlkc_pkg::COUNT_WIDTH_DEFAULT-1:0] blank_total;
        logic [tlkc_pkg::COUNT_WIDTH_DEFAULT-1:0] keyword_total;
        chunk_result_t                            pending_chunks[$];
        int                                       errors;

        function new();
            clear_chunk();
            blank_total   = '0;
            keyword_total = '0;
            errors        = 0;
        endfunction

        function void clear_chunk();
            history      = '0;
            chunk_len    = '0;
            saw_nonblank = 0;
            saw_keyword  = 0;
            saw_comment  = 0;
        endfunction

        // Word of n bytes ends at the newest byte, all of it inside the chunk.
        function bit ends_with(logic [47:0] win, int unsigned avail, logic [47:0] word,
                               int unsigned n);
            logic [63:0] mask;
            mask = (64'd1 << (8 * n)) - 64'd1;
            return (avail >= n) && ((64'(win) & mask) == (64'(word) & mask));
        endfunction

        function void note_request(logic [7:0] c, bit eot);
            logic [47:0]   window;
            int unsigned   avail;
            chunk_result_t r;
            window = {history, c};
            avail  = (int'(chunk_len) + 1 > tlkc_pkg::WIN_BYTES) ?
                     tlkc_pkg::WIN_BYTES : int'(chunk_len) + 1;
            if (c != tlkc_pkg::CH_SPACE && c != tlkc_pkg::CH_TAB &&
                c != tlkc_pkg::CH_CR && c != tlkc_pkg::CH_LF)
                saw_nonblank = 1;
            if (ends_with(window, avail, tlkc_pkg::KW_INT,
                          $bits(tlkc_pkg::KW_INT) / 8)    ||
                ends_with(window, avail, tlkc_pkg::KW_FLOAT,
                          $bits(tlkc_pkg::KW_FLOAT) / 8)  ||
                ends_with(window, avail, tlkc_pkg::KW_RETURN,
                          $bits(tlkc_pkg::KW_RETURN) / 8) ||
                ends_with(window, avail, tlkc_pkg::KW_IF,
                          $bits(tlkc_pkg::KW_IF) / 8)     ||
                ends_with(window, avail, tlkc_pkg::KW_ELSE,
                          $bits(tlkc_pkg::KW_ELSE) / 8)   ||
                ends_with(window, avail, tlkc_pkg::KW_FOR,
                          $bits(tlkc_pkg::KW_FOR) / 8)    ||
                ends_with(window, avail, tlkc_pkg::KW_WHILE,
                          $bits(tlkc_pkg::KW_WHILE) / 8)  ||
                ends_with(window, avail, tlkc_pkg::KW_PRINTF,
                          $bits(tlkc_pkg::KW_PRINTF) / 8))
                saw_keyword = 1;
            if (ends_with(window, avail, tlkc_pkg::CMT_MARK,
                          $bits(tlkc_pkg::CMT_MARK) / 8))
                saw_comment = 1;
            history   = window[39:0];
            chunk_len = chunk_len + 1'b1;

            if (c == tlkc_pkg::CH_LF || chunk_len >= tlkc_pkg::MAX_CHUNK_DEFAULT || eot)
            begin
                if (!saw_nonblank && blank_total != '1)
                    blank_total = blank_total + 1'b1;
                if (saw_keyword && keyword_total != '1)
                    keyword_total = keyword_total + 1'b1;
                r.blank         = !saw_nonblank;
                r.keyword       = saw_keyword;
                r.comment       = saw_comment;
                r.blank_count   = blank_total[tlkc_pkg::OUT_COUNT_W-1:0];
                r.keyword_count = keyword_total[tlkc_pkg::OUT_COUNT_W-1:0];
                r.last          = eot;
                pending_chunks.push_back(r);
                clear_chunk();
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(chunk_result_t got);
            chunk_result_t want;
            if (pending_chunks.size() == 0)
            begin
                $display("%0t: result with nothing pending, actual %p", $time, got);
                errors++;
                return;
            end
            want = pending_chunks.pop_front();
            compare_field("blank",         want.blank,         got.blank);
            compare_field("has_keyword",   want.keyword,       got.keyword);
            compare_field("has_comment",   want.comment,       got.comment);
            compare_field("blank_count",   want.blank_count,   got.blank_count);
            compare_field("keyword_count", want.keyword_count, got.keyword_count);
            compare_field("final_res",     want.last,          got.last);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  ch = 8'h20;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        blank;
    logic        has_keyword;
    logic        has_comment;
    logic [15:0] blank_count;
    logic [15:0] keyword_count;
    logic        final_res;

    chunk_scoreboard sb = new();
    bit              quiet = 0;
    int              bytes_sent = 0;
    int unsigned     cycle_count = 0;
    string           words[9] = '{"int", "float", "return", "if", "else", "for", "while",
                                  "printf", "//"};

    text_line_keyword_classifier uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .ch            (ch),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .blank         (blank),
        .has_keyword   (has_keyword),
        .has_comment   (has_comment),
        .blank_count   (blank_count),
        .keyword_count (keyword_count),
        .final_res     (final_res)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Result side: check on handshake, then pick next ready with random stalls.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(chunk_result_t'({blank, has_keyword, has_comment,
                                                 blank_count, keyword_count, final_res}));
            out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_byte(input logic [7:0] c, input bit eot);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        ch          <= c;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(c, eot);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit eot_on_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot_on_last && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] pick_blank_byte();
        case ($urandom_range(2))
            0: return tlkc_pkg::CH_SPACE;
            1: return tlkc_pkg::CH_TAB;
            default: return tlkc_pkg::CH_CR;
        endcase
    endfunction

    // Appends one token: keywords, near misses, blanks, slashes, letters, raw bytes.
    function automatic void append_token(ref logic [7:0] text[$], input bit blank_only);
        string w;
        if (blank_only)
        begin
            text.push_back(pick_blank_byte());
            return;
        end
        case ($urandom_range(9))
            0, 1:
            begin
                w = words[$urandom_range(8)];
                for (int i = 0; i < w.len(); i++)
                    text.push_back(w[i]);
            end
            2:
            begin
                w = words[$urandom_range(8)];
                for (int i = 0; i < w.len() - 1; i++)
                    text.push_back(w[i]);
            end
            3, 4: text.push_back(pick_blank_byte());
            5:    text.push_back("/");
            6:    text.push_back(8'($urandom_range(1, 255)));
            default: text.push_back(8'($urandom_range("a", "z")));
        endcase
    endfunction

    task automatic send_random_line();
        logic [7:0] text[$];
        int         target;
        int         pick;
        bit         blank_only;
        bit         eot;
        pick = $urandom_range(99);
        if (pick < 70)
            target = $urandom_range(0, 20);
        else if (pick < 92)
            target = $urandom_range(21, 98);
        else
            target = $urandom_range(99, 140);
        blank_only = ($urandom_range(99) < 10);
        while (text.size() < target)
            append_token(text, blank_only);
        if ($urandom_range(99) < 85)
        begin
            text.push_back(tlkc_pkg::CH_LF);
            eot = ($urandom_range(99) < 6);
        end
        else
        begin
            if (text.size() == 0)
                text.push_back(8'($urandom_range(1, 255)));
            eot = 1;
        end
        foreach (text[i])
            send_byte(text[i], eot && (i == text.size() - 1));
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("\t \015\n", 0);
        // printf holds int too; comment and end mark close the chunk together
        send_text("printf//", 1);
        // newline carrying the end mark
        send_text("\n", 1);
        send_byte(8'h01, 0);
        send_byte(8'hFF, 0);
        send_text("if\n", 0);

        while (bytes_sent < ITEM_TARGET)
        begin
            quiet = (bytes_sent > 400 && bytes_sent < 650);
            send_random_line();
        end
        quiet = 0;
        in_valid <= 1'b0;

        while (sb.pending_chunks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0 && sb.pending_chunks.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

// ===== files.f =====
sv/tlkc_pkg.sv
sv/tlkc_front.sv
sv/tlkc_queue.sv
sv/tlkc_back.sv
sv/text_line_keyword_classifier.sv
sv/tlkc_checker.sv
tb/testbench.sv
